// File: rtl/lbp_pkg.sv
`timescale 1ns / 1ps
package lbp_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int PIXEL_BITS  = 8;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int OUT_ROW_BITS = HEIGHT_BITS;
    // input row may run ahead of the output row by up to two rows
    localparam int IN_ROW_BITS = HEIGHT_BITS + 1;
    localparam int CODE_BITS   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef logic [PIXEL_BITS-1:0]  t_pix;
    typedef logic [COL_BITS-1:0]    t_col;
    typedef logic [WIDTH_BITS-1:0]  t_width;
    typedef logic [HEIGHT_BITS-1:0] t_height;

    // one classified item on its way from front to back
    typedef struct packed {
        t_col       col;
        t_pix       pix;
        logic       emit;
        logic       last;
        logic [8:0] nb_mask;   // window positions inside the image, centre bit clear
    } t_job;

endpackage

// File: rtl/lbp_if.sv
`timescale 1ns / 1ps
interface lbp_in_if;
    import lbp_pkg::*;
    logic valid;
    logic ready;
    logic req_type;
    t_pix pixel_value;

    modport source (output valid, output req_type, output pixel_value, input ready);
    modport sink (input valid, input req_type, input pixel_value, output ready);
endinterface

interface lbp_out_if;
    import lbp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] pattern_code;
    logic                 frame_last;

    modport source (output valid, output pattern_code, output frame_last, input ready);
    modport sink (input valid, input pattern_code, input frame_last, output ready);
endinterface

// File: rtl/lbp_front.sv
`timescale 1ns / 1ps
module lbp_front
    import lbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_width      i_width,
    input  t_height     i_height,
    lbp_in_if.sink      i_in,
    output logic        o_push_vld,
    output t_job        o_push_job,
    input  logic        i_push_rdy
);

    logic [COL_BITS-1:0]     r_in_col, n_in_col;
    logic [IN_ROW_BITS-1:0]  r_in_row, n_in_row;
    logic [COL_BITS-1:0]     r_out_col, n_out_col;
    logic [OUT_ROW_BITS-1:0] r_out_row, n_out_row;

    t_width            w_eff;
    t_height           h_eff;
    logic              accept;
    logic              drop;
    logic              flush;
    logic              emit;
    logic              last;
    logic [WIDTH_BITS-1:0]  in_col_inc;
    logic [WIDTH_BITS-1:0]  out_col_inc;
    logic [HEIGHT_BITS-1:0] out_row_inc;
    logic              top_ok, bot_ok, left_ok, right_ok;

    // effective geometry: zero counts as one, width saturates
    always_comb begin
        if (i_width == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (i_width > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = i_width;
        end
        h_eff = (i_height == '0) ? HEIGHT_BITS'(1) : i_height;
    end

    assign i_in.ready = i_push_rdy;
    assign accept     = i_in.valid && i_push_rdy;
    assign flush      = (i_in.req_type == REQ_FLUSH);
    assign drop       = flush && (r_in_row == '0) && (r_in_col == '0);
    assign emit       = (r_in_row >= IN_ROW_BITS'(2))
                     || ((r_in_row == IN_ROW_BITS'(1)) && (r_in_col != '0));

    assign in_col_inc  = WIDTH_BITS'(r_in_col) + WIDTH_BITS'(1);
    assign out_col_inc = WIDTH_BITS'(r_out_col) + WIDTH_BITS'(1);
    assign out_row_inc = HEIGHT_BITS'(r_out_row) + HEIGHT_BITS'(1);
    assign last        = (out_row_inc >= h_eff) && (out_col_inc >= w_eff);

    assign top_ok   = (r_out_row != '0);
    assign bot_ok   = (out_row_inc < h_eff);
    assign left_ok  = (r_out_col != '0);
    assign right_ok = (out_col_inc < w_eff);

    always_comb begin
        o_push_job.col  = r_in_col;
        o_push_job.pix  = (flush || ({1'b0, r_in_row} >= (IN_ROW_BITS + 1)'(h_eff)))
                        ? '0 : i_in.pixel_value;
        o_push_job.emit = emit;
        o_push_job.last = last;
        o_push_job.nb_mask = {bot_ok & right_ok, bot_ok, bot_ok & left_ok,
                              right_ok, 1'b0, left_ok,
                              top_ok & right_ok, top_ok, top_ok & left_ok};
    end

    assign o_push_vld = i_in.valid && !drop;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (accept && !drop) begin
            if (in_col_inc >= w_eff) begin
                n_in_col = '0;
                n_in_row = r_in_row + IN_ROW_BITS'(1);
            end else begin
                n_in_col = in_col_inc[COL_BITS-1:0];
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_col_inc >= w_eff) begin
                    n_out_col = '0;
                    n_out_row = out_row_inc[OUT_ROW_BITS-1:0];
                end else begin
                    n_out_col = out_col_inc[COL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

// File: rtl/lbp_queue.sv
`timescale 1ns / 1ps
module lbp_queue
    import lbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_vld,
    input  t_job i_push_job,
    output logic o_push_rdy,
    output logic o_pop_vld,
    output t_job o_pop_job,
    input  logic i_pop_rdy
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;
    logic                 push;
    logic                 pop;

    assign o_push_rdy = (r_count != (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_pop_vld  = (r_count != '0);
    assign o_pop_job  = r_mem[r_rd_ptr];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (QPTR_BITS + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_BITS + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/lbp_back.sv
`timescale 1ns / 1ps
module lbp_back
    import lbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pop_vld,
    input  t_job    i_pop_job,
    output logic    o_pop_rdy,
    lbp_out_if.source o_out
);

    localparam int WORD_BITS = 2 * PIXEL_BITS;

    // each line buffer word holds {row above, current row} for one column
    logic [WORD_BITS-1:0] r_line [MAX_WIDTH];
    logic [WORD_BITS-1:0] r_rd;

    logic                 r_s1_vld;
    t_job                 r_s1;
    logic                 r_s1_fwd;
    logic [WORD_BITS-1:0] r_s1_fwd_word;

    t_pix                 r_win [9];
    t_pix                 n_win [9];

    logic                 r_out_vld;
    logic [CODE_BITS-1:0] r_code;
    logic                 r_last;

    logic                 adv;
    logic                 pop;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] wr_word;
    t_pix                 top_pix;
    t_pix                 mid_pix;
    t_pix                 centre;
    logic [CODE_BITS-1:0] code;
    logic [3:0]           nbit;

    assign adv       = !r_out_vld || o_out.ready;
    assign o_pop_rdy = adv;
    assign pop       = adv && i_pop_vld;

    // previous item wrote the same column in the cycle this item's word was read: take its word
    assign rd_word = r_s1_fwd ? r_s1_fwd_word : r_rd;
    assign top_pix = rd_word[WORD_BITS-1:PIXEL_BITS];
    assign mid_pix = rd_word[PIXEL_BITS-1:0];
    assign wr_word = {mid_pix, r_s1.pix};

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = top_pix;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = mid_pix;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1.pix;
    end

    // dense packing of the in-image neighbours
    always_comb begin
        centre = n_win[4];
        code   = '0;
        nbit   = '0;
        for (int k = 0; k < 9; k++) begin
            if (r_s1.nb_mask[k]) begin
                if (n_win[k] >= centre) begin
                    code[nbit[2:0]] = 1'b1;
                end
                nbit = nbit + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd <= r_line[i_pop_job.col];
        end
        if (adv && r_s1_vld) begin
            r_line[r_s1.col] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1          <= i_pop_job;
            r_s1_fwd_word <= wr_word;
        end
        if (adv) begin
            r_code <= code;
            r_last <= r_s1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_fwd  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (adv) begin
            r_s1_vld  <= i_pop_vld;
            r_s1_fwd  <= i_pop_vld && r_s1_vld && (i_pop_job.col == r_s1.col);
            r_out_vld <= r_s1_vld && r_s1.emit;
            if (r_s1_vld) begin
                r_win <= n_win;
            end
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.pattern_code = r_code;
    assign o_out.frame_last   = r_last;

endmodule

// File: rtl/local_binary_pattern_filter_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake       payload
// i_in      in   valid / ready   req_type, pixel_value
// o_out     out  valid / ready   pattern_code, frame_last
// apb       in   psel / penable  paddr, pwdata -> prdata (image_width, image_height)
//
// one item per clock sustained while the output is not stalled; an item passes a
// queue slot, the line buffer read register and the output register on its way out
// patterns lag the pixel stream by image_width+1 items, drained by flush or pixel transactions
// synchronous active-low reset clears counters, window and pipeline valids;
// the line buffer memory is not cleared
// a stalled output holds the back pipeline; the four-entry queue lets the
// front keep taking transactions meanwhile until it fills
module local_binary_pattern_filter_core
    import lbp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    lbp_in_if.sink                   i_in,
    lbp_out_if.source                o_out
);

    t_width  r_width;
    t_height r_height;
    logic    cfg_wr;
    logic    reg_idx;

    logic    push_vld;
    t_job    push_job;
    logic    push_rdy;
    logic    pop_vld;
    t_job    pop_job;
    logic    pop_rdy;

    // apb register file, zero wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_BITS'(640);
            r_height <= HEIGHT_BITS'(480);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IDX_WIDTH:  r_width  <= pwdata[WIDTH_BITS-1:0];
                REG_IDX_HEIGHT: r_height <= pwdata[HEIGHT_BITS-1:0];
                default:        r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IDX_WIDTH:  prdata = APB_DATA_BITS'(r_width);
            REG_IDX_HEIGHT: prdata = APB_DATA_BITS'(r_height);
            default:        prdata = '0;
        endcase
    end

    // front: raster position tracking, flush handling, boundary classification
    lbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_in       (i_in),
        .o_push_vld (push_vld),
        .o_push_job (push_job),
        .i_push_rdy (push_rdy)
    );

    // decouples the front from output stalls
    lbp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (push_vld),
        .i_push_job (push_job),
        .o_push_rdy (push_rdy),
        .o_pop_vld  (pop_vld),
        .o_pop_job  (pop_job),
        .i_pop_rdy  (pop_rdy)
    );

    // back: line buffers, 3x3 window, pattern compare and output register
    lbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pop_vld (pop_vld),
        .i_pop_job (pop_job),
        .o_pop_rdy (pop_rdy),
        .o_out     (o_out)
    );

endmodule

// File: sim/lbp_pattern_check.sv
`timescale 1ns / 1ps
module lbp_pattern_check
    import lbp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic [APB_DATA_BITS-1:0] prdata,
    input  logic                     pready,
    lbp_in_if                        pix_ch,
    lbp_out_if                       pat_ch,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int REG_SEL_BIT  = 2;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 last;
    } t_lbp_result;

    t_width      width_reg;
    t_height     height_reg;
    t_pix        line_buf [2*MAX_WIDTH];
    t_pix        win [9];
    int unsigned in_col;
    int unsigned in_row;
    int unsigned out_col;
    int unsigned out_row;
    t_lbp_result expected_q [$];
    int          errors = 0;
    int          checked = 0;

    function automatic int unsigned frame_width();
        if (width_reg == '0) return 1;
        if (width_reg > t_width'(MAX_WIDTH)) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int unsigned frame_height();
        if (height_reg == '0) return 1;
        return int'(height_reg);
    endfunction

    // in-image neighbours of the current output centre, packed from bit 0
    function automatic logic [CODE_BITS-1:0] window_code(int unsigned w, int unsigned h);
        logic [CODE_BITS-1:0] code;
        int                   nbit;
        int                   r;
        int                   c;
        code = '0;
        nbit = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                r = int'(out_row) + dr;
                c = int'(out_col) + dc;
                if ((dr != 0 || dc != 0) && r >= 0 && c >= 0 && r < int'(h) && c < int'(w)) begin
                    if (win[(dr + 1) * 3 + dc + 1] >= win[4]) code[nbit] = 1'b1;
                    nbit++;
                end
            end
        end
        return code;
    endfunction

    task automatic take_item(input logic req, input t_pix pix);
        t_pix        fresh;
        t_pix        upper;
        t_pix        middle;
        int unsigned w;
        int unsigned h;
        logic        emit;
        t_lbp_result res;
        w = frame_width();
        h = frame_height();
        // flush before the first pixel of a frame does nothing
        if (in_row == 0 && in_col == 0 && req == REQ_FLUSH) return;
        fresh = (req == REQ_FLUSH || in_row >= h) ? '0 : pix;
        upper  = line_buf[in_col];
        middle = line_buf[MAX_WIDTH + in_col];
        line_buf[in_col]             = middle;
        line_buf[MAX_WIDTH + in_col] = fresh;
        for (int k = 0; k < 3; k++) begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = upper;
        win[5] = middle;
        win[8] = fresh;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
        if (!emit) return;
        res.code = window_code(w, h);
        if (out_row + 1 >= h && out_col + 1 >= w) begin
            res.last = 1'b1;
            in_col   = 0;
            in_row   = 0;
            out_col  = 0;
            out_row  = 0;
        end else begin
            res.last = 1'b0;
            if (out_col + 1 >= w) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        end
        expected_q.push_back(res);
    endtask

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) $display("mismatch %0d at %0t: %s", errors, $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_lbp_result             want;
        logic [APB_DATA_BITS-1:0] reg_value;
        if (!i_rst_n) begin
            width_reg  = t_width'(RESET_WIDTH);
            height_reg = t_height'(RESET_HEIGHT);
            foreach (line_buf[k]) line_buf[k] = '0;
            foreach (win[k]) win[k] = '0;
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            expected_q.delete();
        end else begin
            if (pat_ch.valid && pat_ch.ready) begin
                if (expected_q.size() == 0) begin
                    flag_error($sformatf("pattern %02h last %0b with nothing expected",
                                         pat_ch.pattern_code, pat_ch.frame_last));
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (want.code !== pat_ch.pattern_code || want.last !== pat_ch.frame_last)
                        flag_error($sformatf("pattern expected %02h last %0b, got %02h last %0b",
                                             want.code, want.last,
                                             pat_ch.pattern_code, pat_ch.frame_last));
                end
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[REG_SEL_BIT] == REG_IDX_HEIGHT) height_reg = pwdata[HEIGHT_BITS-1:0];
                    else width_reg = pwdata[WIDTH_BITS-1:0];
                end else begin
                    reg_value = (paddr[REG_SEL_BIT] == REG_IDX_HEIGHT) ?
                                APB_DATA_BITS'(height_reg) : APB_DATA_BITS'(width_reg);
                    if (prdata !== reg_value)
                        flag_error($sformatf("register read at %0h expected %0h, got %0h",
                                             paddr, reg_value, prdata));
                end
            end
            if (pix_ch.valid && pix_ch.ready) take_item(pix_ch.req_type, pix_ch.pixel_value);
        end
        o_fail_count <= errors;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import lbp_pkg::*;

    // random part length and quiet cycles before a register write or the end
    localparam int RANDOM_ITEMS  = 1150;
    localparam int SETTLE_CYCLES = 8;
    localparam int IN_FLUSH_PCT  = 8;

    // idling phases: none, sender only, receiver only, both
    localparam int IDLE_IN  [4] = '{0, 46, 0, 20};
    localparam int STALL_OUT[4] = '{0, 0, 46, 20};

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    lbp_in_if  pix_ch ();
    lbp_out_if pat_ch ();

    int fail_count;
    int pending;
    int checked;

    // percentages the drivers use right now
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // effective frame size of the current register setting
    int frame_w = 1;
    int frame_h = 1;

    // what the run went through, for the summary
    int sent   = 0;
    int frames = 0;
    int setups = 0;

    local_binary_pattern_filter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (pix_ch),
        .o_out   (pat_ch)
    );

    // watches both channels and the register port, predicts every pattern
    lbp_pattern_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pix_ch       (pix_ch),
        .pat_ch       (pat_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // receiver side: random backpressure, rate set by the current phase
    always @(posedge i_clk) begin
        pat_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d patterns still outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // one pixel channel transaction, with random idle cycles ahead of it;
    // payload is scrambled while valid is low so nothing may sample it then
    task automatic push_item(input logic req, input t_pix pix);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_ch.valid       <= 1'b0;
            pix_ch.req_type    <= ($urandom_range(0, 1) != 0) ? REQ_FLUSH : REQ_PIXEL;
            pix_ch.pixel_value <= t_pix'($urandom);
            @(posedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.req_type    <= req;
        pix_ch.pixel_value <= pix;
        do @(posedge i_clk); while (!pix_ch.ready);
        sent++;
    endtask

    // flushes that are dropped: ahead of a frame or past the drain
    task automatic push_flushes(input int count);
        repeat (count) push_item(REQ_FLUSH, t_pix'($urandom));
    endtask

    // stop sending, let every predicted pattern arrive, then let the pipe settle
    // since trailing flushes leave nothing to wait for
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup cycle then access cycle; the bus is released after
    task automatic apb_access(input logic wr, input logic sel, input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_BITS'({sel, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // new frame size, only with the block idle; upper bus bits sometimes junk,
    // both registers read back afterwards
    task automatic set_size(input int raw_w, input int raw_h);
        logic [APB_DATA_BITS-1:0] wdata;
        wait_idle();
        wdata = ($urandom_range(0, 3) == 0) ? APB_DATA_BITS'($urandom) : '0;
        wdata[WIDTH_BITS-1:0] = raw_w[WIDTH_BITS-1:0];
        apb_access(1'b1, REG_IDX_WIDTH, wdata);
        wdata = ($urandom_range(0, 3) == 0) ? APB_DATA_BITS'($urandom) : '0;
        wdata[HEIGHT_BITS-1:0] = raw_h[HEIGHT_BITS-1:0];
        apb_access(1'b1, REG_IDX_HEIGHT, wdata);
        apb_access(1'b0, REG_IDX_WIDTH, '0);
        apb_access(1'b0, REG_IDX_HEIGHT, '0);
        // zero means one, width saturates at the line buffer size
        frame_w = (raw_w == 0) ? 1 : ((raw_w > MAX_WIDTH) ? MAX_WIDTH : raw_w);
        frame_h = (raw_h == 0) ? 1 : raw_h;
        setups++;
    endtask

    // values biased toward the rails and toward near-equal neighbours
    function automatic t_pix pick_pixel();
        case ($urandom_range(0, 3))
            0: return t_pix'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return t_pix'($urandom_range(126, 130));
        endcase
    endfunction

    // a complete frame: raster items with some black flushes inside, first item
    // always a pixel so the frame really starts, then width+1 drain items mixing
    // flushes and pixels whose values must be ignored
    task automatic run_frame(input int flush_pct);
        push_item(REQ_PIXEL, pick_pixel());
        for (int i = 1; i < frame_w * frame_h; i++) begin
            if ($urandom_range(0, 99) < flush_pct) push_item(REQ_FLUSH, t_pix'($urandom));
            else push_item(REQ_PIXEL, pick_pixel());
        end
        for (int i = 0; i <= frame_w; i++) begin
            push_item(($urandom_range(0, 1) != 0) ? REQ_FLUSH : REQ_PIXEL, t_pix'($urandom));
        end
        frames++;
    endtask

    initial begin
        int rand_items;
        int phase;
        int raw_w;
        int raw_h;

        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.req_type    <= REQ_PIXEL;
        pix_ch.pixel_value <= '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register values after reset
        apb_access(1'b0, REG_IDX_WIDTH, '0);
        apb_access(1'b0, REG_IDX_HEIGHT, '0);

        // directed 3x3 frame with every special case on the pixel channel
        set_size(3, 3);
        push_flushes(2);                          // flush at frame start, dropped
        push_item(REQ_PIXEL, 8'hFF);
        push_item(REQ_PIXEL, 8'h00);
        push_item(REQ_PIXEL, 8'h80);
        push_item(REQ_FLUSH, 8'hA5);              // inside the frame: a black pixel
        push_item(REQ_PIXEL, 8'hFF);
        push_item(REQ_PIXEL, 8'h00);
        push_item(REQ_PIXEL, 8'h01);
        push_item(REQ_PIXEL, 8'hFE);
        push_item(REQ_PIXEL, 8'h80);
        push_item(REQ_PIXEL, 8'h4D);              // pixel during drain acts as flush
        push_item(REQ_FLUSH, 8'h00);
        push_item(REQ_PIXEL, 8'hC8);
        push_item(REQ_FLUSH, 8'h00);              // completes drain, frame_last here
        push_flushes(2);                          // beyond the drain, dropped
        frames++;

        // zero registers read as a single pixel frame
        set_size(0, 0);
        push_item(REQ_PIXEL, 8'hC8);
        push_item(REQ_FLUSH, 8'h00);
        push_item(REQ_PIXEL, 8'h05);
        frames++;

        // random frames, small sizes, sweeping the idling phases
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            phase         = rand_items * 4 / RANDOM_ITEMS;
            send_idle_pct = IDLE_IN[phase];
            stall_pct     = STALL_OUT[phase];
            // frames often follow back to back under the same size
            if (rand_items == 0 || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0: raw_w = 0;
                    1, 2: raw_w = $urandom_range(11, 32);
                    default: raw_w = $urandom_range(1, 10);
                endcase
                case ($urandom_range(0, 9))
                    0: raw_h = 0;
                    1: raw_h = $urandom_range(9, 16);
                    default: raw_h = $urandom_range(1, 8);
                endcase
                set_size(raw_w, raw_h);
            end
            if ($urandom_range(0, 4) == 0) push_flushes($urandom_range(1, 2));
            run_frame(IN_FLUSH_PCT);
            rand_items += frame_w * frame_h + frame_w + 1;
            if ($urandom_range(0, 4) == 0) push_flushes($urandom_range(1, 3));
        end

        // register extremes written and read back, then a small frame after them
        set_size(2047, 8191);
        set_size(3, 2);
        run_frame(IN_FLUSH_PCT);

        wait_idle();
        $display("covered %0d frames under %0d register settings, %0d pixel channel transactions",
                 frames, setups, sent);
        $display("compared %0d patterns, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
